>>> rtl/rhsh_pkg.sv
// ----------------------------------------------------------------------------
// rhsh_pkg: shared constants, types and a function
// Twister constants, store sizes, register indexes and the tempering step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rhsh_pkg;

  localparam int MAX_SPOTS     = 4096;
  localparam int MAX_HASH_BITS = 60;
  localparam int ACC_WIDTH     = 48;
  localparam int SPOT_AW       = $clog2(MAX_SPOTS);
  localparam int SPOT_CW       = $clog2(MAX_SPOTS + 1);
  localparam int BITS_W        = $clog2(MAX_HASH_BITS + 1);

  localparam int MT_N  = 312;
  localparam int MT_M  = 156;
  localparam int MT_AW = $clog2(MT_N);

  localparam logic [63:0] MT_MATRIX    = 64'hB5026F5AA96619E9;
  localparam logic [63:0] MT_UPPER     = 64'hFFFFFFFF80000000;
  localparam logic [63:0] MT_LOWER     = 64'h000000007FFFFFFF;
  localparam logic [63:0] MT_INIT_MULT = 64'd6364136223846793005;
  localparam logic [63:0] GOLDEN       = 64'h9E3779B97F4A7C15;

  localparam logic [1:0] REG_HASH_BITS  = 2'd0;
  localparam logic [1:0] REG_SPOT_COUNT = 2'd1;
  localparam logic [1:0] REG_SEED       = 2'd2;
  localparam logic [1:0] REG_TABLE      = 2'd3;

  typedef struct packed {
    logic [BITS_W-1:0]  nb;
    logic [SPOT_CW-1:0] n;
  } cfg_eff_t;

  function automatic logic [63:0] temper(input logic [63:0] w);
    logic [63:0] y;
    y = w;
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage
`default_nettype wire

>>> rtl/random_hyperplane_sign_hash_unit.sv
// ----------------------------------------------------------------------------
// random_hyperplane_sign_hash_unit: random-hyperplane sign hash, one table
// Hashes columns of Q16.16 samples into bucket ids using generated signs.
// ----------------------------------------------------------------------------
// Use: write hash_bits, spot_count, seed_value and table_number through the
// cfg channel (index 0..3) while no column is in flight; cfg_ready is always
// high. Every write, and reset, restarts the sign fill: the twister is seeded,
// its words are regenerated before the first draw and after every 312 draws,
// and one draw is made for each of hash_bits*spot_count signs. Samples are
// accepted into a two-beat queue during the fill and are consumed once it is
// done. After the fill one sample beat is taken per cycle unless a finished
// result is held back, each beat reading the sign store through its port b.
// The bucket id and gene index go through the s1 and output registers
// once the queue releases a column's last sample. While out_tready is low
// the result holds, the current column keeps accumulating, and input stalls
// only when the finished next result finds the output register still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module random_hyperplane_sign_hash_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,   // [59:0] bucket_id, [75:60] gene_index
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [5:0]  hash_bits_r;
  logic [12:0] spot_count_r;
  logic [31:0] seed_r;
  logic [9:0]  table_r;
  logic        cfg_wr;
  rhsh_pkg::cfg_eff_t cfg_eff;

  logic        q_valid, q_pop, signs_ready;
  logic [31:0] q_data;
  logic        sw_en, sr_en_b;
  logic [rhsh_pkg::SPOT_AW-1:0] sw_addr, sr_addr_a, sr_addr_b;
  logic [rhsh_pkg::MAX_HASH_BITS-1:0] sw_data, sr_data_a, sr_data_b;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (hash_bits_r == 6'd0) begin
      cfg_eff.nb = rhsh_pkg::BITS_W'(1);
    end else if (hash_bits_r > 6'(rhsh_pkg::MAX_HASH_BITS)) begin
      cfg_eff.nb = rhsh_pkg::BITS_W'(rhsh_pkg::MAX_HASH_BITS);
    end else begin
      cfg_eff.nb = rhsh_pkg::BITS_W'(hash_bits_r);
    end
    if (spot_count_r == 13'd0) begin
      cfg_eff.n = rhsh_pkg::SPOT_CW'(1);
    end else if (spot_count_r > 13'(rhsh_pkg::MAX_SPOTS)) begin
      cfg_eff.n = rhsh_pkg::SPOT_CW'(rhsh_pkg::MAX_SPOTS);
    end else begin
      cfg_eff.n = rhsh_pkg::SPOT_CW'(spot_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_bits_r  <= 6'd12;
      spot_count_r <= 13'd4096;
      seed_r       <= 32'd1;
      table_r      <= 10'd0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rhsh_pkg::REG_HASH_BITS:  hash_bits_r  <= cfg_data[5:0];
        rhsh_pkg::REG_SPOT_COUNT: spot_count_r <= cfg_data[12:0];
        rhsh_pkg::REG_SEED:       seed_r       <= cfg_data;
        rhsh_pkg::REG_TABLE:      table_r      <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  rhsh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  rhsh_signgen u_signgen (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (cfg_wr),
    .seed_value   (seed_r),
    .table_number (table_r),
    .cfg          (cfg_eff),
    .signs_ready  (signs_ready),
    .sw_en        (sw_en),
    .sw_addr      (sw_addr),
    .sw_data      (sw_data),
    .sr_addr      (sr_addr_a),
    .sr_data      (sr_data_a)
  );

  rhsh_ram #(.WIDTH(rhsh_pkg::MAX_HASH_BITS), .DEPTH(rhsh_pkg::MAX_SPOTS)) u_signs (
    .clk     (clk),
    .we      (sw_en),
    .waddr   (sw_addr),
    .wdata   (sw_data),
    .re_a    (1'b1),
    .raddr_a (sr_addr_a),
    .rdata_a (sr_data_a),
    .re_b    (sr_en_b),
    .raddr_b (sr_addr_b),
    .rdata_b (sr_data_b)
  );

  rhsh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (cfg_wr),
    .signs_ready (signs_ready),
    .cfg         (cfg_eff),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .sr_en       (sr_en_b),
    .sr_addr     (sr_addr_b),
    .sr_data     (sr_data_b),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/rhsh_ram.sv
// ----------------------------------------------------------------------------
// rhsh_ram: generic RAM
// One write port, two read ports with enable and registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic                     re_b,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule
`default_nettype wire

>>> rtl/rhsh_front.sv
// ----------------------------------------------------------------------------
// rhsh_front: sample intake
// Two-entry queue that takes sample beats and hands them to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhsh_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  output logic             q_valid,
  output logic [31:0]      q_data,
  input  wire logic        q_pop
);

  logic [31:0] mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_tdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push) |=> (cnt_r == 2'd0 || $past(in_tvalid)))
    else $error("queue filled without a beat");

endmodule
`default_nettype wire

>>> rtl/rhsh_signgen.sv
// ----------------------------------------------------------------------------
// rhsh_signgen: hyperplane sign generator
// Seeds a 64-bit twister, regenerates its words and fills the sign store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhsh_signgen (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          restart,
  input  wire logic [31:0]                   seed_value,
  input  wire logic [9:0]                    table_number,
  input  wire rhsh_pkg::cfg_eff_t            cfg,
  output logic                               signs_ready,
  output logic                               sw_en,
  output logic [rhsh_pkg::SPOT_AW-1:0]       sw_addr,
  output logic [rhsh_pkg::MAX_HASH_BITS-1:0] sw_data,
  output logic [rhsh_pkg::SPOT_AW-1:0]       sr_addr,
  input  wire logic [rhsh_pkg::MAX_HASH_BITS-1:0] sr_data
);

  localparam logic [2:0] S_GOLD    = 3'd0;
  localparam logic [2:0] S_SEED    = 3'd1;
  localparam logic [2:0] S_GEN_A   = 3'd2;
  localparam logic [2:0] S_GEN_B   = 3'd3;
  localparam logic [2:0] S_GEN_C   = 3'd4;
  localparam logic [2:0] S_DRAW_RD = 3'd5;
  localparam logic [2:0] S_DRAW_WR = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  localparam int AW = rhsh_pkg::MT_AW;
  localparam logic [AW-1:0] LAST_W  = AW'(rhsh_pkg::MT_N - 1);
  localparam logic [AW:0]   POS_END = (AW+1)'(rhsh_pkg::MT_N);

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [63:0]   prod_r, lo_r, lo_nxt, p_r, p_nxt, wi_r, wi_nxt, wn_r, wn_nxt;
  logic [31:0]   cross_r, cross_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW:0]   pos_r, pos_nxt;
  logic [rhsh_pkg::BITS_W-1:0]  bit_r, bit_nxt;
  logic [rhsh_pkg::SPOT_AW-1:0] spot_r, spot_nxt;

  logic [63:0]   op_a, op_b, res, x, t, y;
  logic [31:0]   mul_a, mul_b;
  logic [10:0]   tbl1;
  logic          tw_we;
  logic [AW-1:0] tw_wa, tw_ra0, tw_ra1;
  logic [63:0]   tw_wd, tw_rd0, tw_rd1;
  logic [AW:0]   mid;

  rhsh_ram #(.WIDTH(64), .DEPTH(rhsh_pkg::MT_N)) u_words (
    .clk     (clk),
    .we      (tw_we),
    .waddr   (tw_wa),
    .wdata   (tw_wd),
    .re_a    (1'b1),
    .raddr_a (tw_ra0),
    .rdata_a (tw_rd0),
    .re_b    (1'b1),
    .raddr_b (tw_ra1),
    .rdata_b (tw_rd1)
  );

  assign tbl1  = {1'b0, table_number} + 11'd1;
  assign op_a  = (state_r == S_GOLD) ? rhsh_pkg::GOLDEN : (p_r ^ (p_r >> 62));
  assign op_b  = (state_r == S_GOLD) ? {53'd0, tbl1} : rhsh_pkg::MT_INIT_MULT;
  assign mul_a = (k_r == 2'd1) ? op_a[63:32] : op_a[31:0];
  assign mul_b = (k_r == 2'd2) ? op_b[63:32] : op_b[31:0];
  assign res   = lo_r + {cross_r + prod_r[31:0], 32'd0};
  assign x     = (wi_r & rhsh_pkg::MT_UPPER) | (wn_r & rhsh_pkg::MT_LOWER);
  assign t     = (x >> 1) ^ (x[0] ? rhsh_pkg::MT_MATRIX : 64'd0);
  assign y     = rhsh_pkg::temper(tw_rd0);
  assign mid   = {1'b0, idx_r} + (AW+1)'(rhsh_pkg::MT_M);
  assign signs_ready = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r + 2'd1;
    lo_nxt    = (k_r == 2'd1) ? prod_r : lo_r;
    cross_nxt = (k_r == 2'd2) ? prod_r[31:0] : cross_r;
    p_nxt     = p_r;
    wi_nxt    = wi_r;
    wn_nxt    = wn_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    bit_nxt   = bit_r;
    spot_nxt  = spot_r;
    tw_we     = 1'b0;
    tw_wa     = idx_r;
    tw_wd     = res;
    tw_ra0    = idx_r;
    tw_ra1    = (idx_r == LAST_W) ? '0 : idx_r + AW'(1);
    sw_en     = 1'b0;
    sw_addr   = spot_r;
    sw_data   = ((bit_r == '0) ? '0 : sr_data) |
                ({{(rhsh_pkg::MAX_HASH_BITS-1){1'b0}}, y[0]} << bit_r);
    sr_addr   = spot_r;
    unique case (state_r)
      S_GOLD: begin
        if (k_r == 2'd3) begin
          tw_we     = 1'b1;
          tw_wa     = '0;
          tw_wd     = res + {{32{seed_value[31]}}, seed_value};
          p_nxt     = tw_wd;
          idx_nxt   = AW'(1);
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        if (k_r == 2'd3) begin
          tw_we = 1'b1;
          tw_wd = res + {{(64-AW){1'b0}}, idx_r};
          p_nxt = tw_wd;
          if (idx_r == LAST_W) begin
            pos_nxt   = POS_END;
            bit_nxt   = '0;
            spot_nxt  = '0;
            state_nxt = S_DRAW_RD;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      S_GEN_A: begin
        state_nxt = S_GEN_B;
      end
      S_GEN_B: begin
        wi_nxt    = tw_rd0;
        wn_nxt    = tw_rd1;
        tw_ra0    = (mid >= (AW+1)'(rhsh_pkg::MT_N)) ?
                    AW'(mid - (AW+1)'(rhsh_pkg::MT_N)) : AW'(mid);
        state_nxt = S_GEN_C;
      end
      S_GEN_C: begin
        tw_we = 1'b1;
        tw_wd = tw_rd0 ^ t;
        if (idx_r == LAST_W) begin
          pos_nxt   = '0;
          state_nxt = S_DRAW_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_GEN_A;
        end
      end
      S_DRAW_RD: begin
        tw_ra0 = pos_r[AW-1:0];
        if (pos_r == POS_END) begin
          idx_nxt   = '0;
          state_nxt = S_GEN_A;
        end else begin
          state_nxt = S_DRAW_WR;
        end
      end
      S_DRAW_WR: begin
        sw_en     = 1'b1;
        pos_nxt   = pos_r + (AW+1)'(1);
        state_nxt = S_DRAW_RD;
        if ({1'b0, spot_r} + rhsh_pkg::SPOT_CW'(1) == cfg.n) begin
          spot_nxt = '0;
          if (bit_r + rhsh_pkg::BITS_W'(1) == cfg.nb) begin
            state_nxt = S_DONE;
          end else begin
            bit_nxt = bit_r + rhsh_pkg::BITS_W'(1);
          end
        end else begin
          spot_nxt = spot_r + rhsh_pkg::SPOT_AW'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
        state_nxt = S_GOLD;
      end
    endcase
    if (state_r != S_GOLD && state_r != S_SEED) begin
      k_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= S_GOLD;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    lo_r    <= lo_nxt;
    cross_r <= cross_nxt;
    p_r     <= p_nxt;
    wi_r    <= wi_nxt;
    wn_r    <= wn_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    bit_r   <= bit_nxt;
    spot_r  <= spot_nxt;
  end

  a_regen_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN_C && idx_r == LAST_W && !restart) |=> (pos_r == '0))
    else $error("draw position not rewound after regeneration");
  a_seed_to_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEED && k_r == 2'd3 && idx_r == LAST_W && !restart)
      |=> (state_r == S_DRAW_RD && pos_r == POS_END))
    else $error("seeding did not hand over to draws");

endmodule
`default_nettype wire

>>> rtl/rhsh_back.sv
// ----------------------------------------------------------------------------
// rhsh_back: projection accumulate and bucket id output
// Adds or subtracts each sample into every hash bit accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhsh_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clear,
  input  wire logic                          signs_ready,
  input  wire rhsh_pkg::cfg_eff_t            cfg,
  input  wire logic                          q_valid,
  input  wire logic [31:0]                   q_data,
  output logic                               q_pop,
  output logic                               sr_en,
  output logic [rhsh_pkg::SPOT_AW-1:0]       sr_addr,
  input  wire logic [rhsh_pkg::MAX_HASH_BITS-1:0] sr_data,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [79:0]                        out_tdata
);

  localparam int NB = rhsh_pkg::MAX_HASH_BITS;
  localparam int AC = rhsh_pkg::ACC_WIDTH;

  logic [rhsh_pkg::SPOT_AW-1:0] spot_r, spot_nxt;
  logic          s1_v_r, s1_v_nxt, s1_last_r, s1_last_nxt;
  logic [31:0]   s1_sample_r;
  logic [AC-1:0] acc_r [NB];
  logic [AC-1:0] acc_sum [NB];
  logic [AC-1:0] v;
  logic [15:0]   col_r;
  logic          out_v_r, out_v_nxt;
  logic [NB-1:0] out_id_r, id_nxt;
  logic [15:0]   out_gi_r;
  logic          fire, adv, last_in;

  assign fire    = s1_v_r && !(s1_last_r && out_v_r && !out_tready);
  assign adv     = !s1_v_r || fire;
  assign q_pop   = adv && q_valid && signs_ready && !clear;
  assign sr_en   = adv;
  assign sr_addr = spot_r;
  assign last_in = ({1'b0, spot_r} + rhsh_pkg::SPOT_CW'(1) == cfg.n);
  assign v       = {{(AC-32){s1_sample_r[31]}}, s1_sample_r};

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_gi_r, out_id_r};

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      acc_sum[b] = sr_data[b] ? acc_r[b] + v : acc_r[b] - v;
      id_nxt[b]  = (b < int'(cfg.nb)) && !acc_sum[b][AC-1];
    end
    spot_nxt    = spot_r;
    s1_v_nxt    = adv ? 1'b0 : s1_v_r;
    s1_last_nxt = s1_last_r;
    if (q_pop) begin
      s1_v_nxt    = 1'b1;
      s1_last_nxt = last_in;
      spot_nxt    = last_in ? '0 : spot_r + rhsh_pkg::SPOT_AW'(1);
    end
    out_v_nxt = (fire && s1_last_r) ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      col_r   <= '0;
      for (int b = 0; b < NB; b++) begin
        acc_r[b] <= '0;
      end
    end else begin
      out_v_r <= out_v_nxt;
      if (clear) begin
        spot_r <= '0;
        s1_v_r <= 1'b0;
        for (int b = 0; b < NB; b++) begin
          acc_r[b] <= '0;
        end
      end else begin
        spot_r <= spot_nxt;
        s1_v_r <= s1_v_nxt;
        if (fire) begin
          for (int b = 0; b < NB; b++) begin
            acc_r[b] <= s1_last_r ? '0 : acc_sum[b];
          end
        end
      end
      if (fire && s1_last_r) begin
        col_r <= col_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_sample_r <= q_data;
      s1_last_r   <= s1_last_nxt;
    end
    if (fire && s1_last_r) begin
      out_id_r <= id_nxt;
      out_gi_r <= col_r;
    end
  end

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r) |=> out_v_r)
    else $error("finished column produced no result");
  a_pop_needs_signs: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (signs_ready && q_valid))
    else $error("sample taken before signs were ready");
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r) |=> (col_r == $past(col_r) + 16'd1))
    else $error("column count did not advance");

endmodule
`default_nettype wire
